FILE: hw/rtl/bbr_pkg.sv
// Package for the bad block remap table: constants, register indexes,
// status codes, sequencer states and the table entry layout.
// No dependencies.
`default_nettype none

package bbr_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 64;

  localparam int unsigned LBA_W   = 64;
  localparam int unsigned LEN_W   = 32;
  localparam int unsigned COUNT_W = 7;

  // The reset start limit is 1000 * 10 times 2097152 blocks.
  localparam logic [LBA_W-1:0] START_LIMIT_RST = LBA_W'(64'd2097152 * 64'd1000 * 64'd10);
  localparam logic [LBA_W-1:0] SPARE_BASE_RST  = '0;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_BASE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_LIMIT = 1'd1;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_ADD    = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_LIMIT = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_ADD_RD,
    S_ADD_SUM,
    S_WRITE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [LBA_W-1:0] orig_start;
    logic [LBA_W-1:0] repl_start;
    logic [LEN_W-1:0] ext_length;
  } entry_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bbr_ifs.sv
// Valid/ready channel interfaces for request and result words.
// Depends on bbr_pkg.
`default_nettype none

interface bbr_req_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [bbr_pkg::LBA_W-1:0] lba;
  logic [bbr_pkg::LEN_W-1:0] run_length;

  modport source (output valid, func, lba, run_length, input ready);
  modport sink (input valid, func, lba, run_length, output ready);
endinterface

interface bbr_rsp_if;
  logic                        valid;
  logic                        ready;
  bbr_pkg::status_t            status;
  logic [bbr_pkg::LBA_W-1:0]   new_start;
  logic [bbr_pkg::COUNT_W-1:0] entry_count;

  modport source (output valid, status, new_start, entry_count, input ready);
  modport sink (input valid, status, new_start, entry_count, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/bbr_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module bbr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/bad_block_remap_table_unit.sv
// Top level of the bad block remap table: sequencer, configuration registers
// and output register around one table RAM.
// Depends on bbr_pkg, bbr_ifs and bbr_ram.
//
//   Channel   Direction  Word
//   in_chan   sink       func, lba, run_length
//   out_chan  source     status, new_start, entry_count
//   cfg_*     write      cfg_index selects spare_base or start_limit
//
// A lookup reads one table entry a cycle through the single RAM read port until
// a hit or the end of the filled entries; an add maps the new run just after the
// last entry's spare run, or to spare_base on an empty table, unless refused.
// One word is in work at a time; the next is accepted once the result sits in
// the output register, even while that register waits to be taken.
// Reset empties the table by clearing the fill count; entries are not cleared.
`default_nettype none

module bad_block_remap_table_unit #(
  parameter int unsigned TABLE_DEPTH = bbr_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  bbr_req_if.sink                               in_chan,
  bbr_rsp_if.source                             out_chan,
  input  wire logic                             cfg_we,
  input  wire logic [bbr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bbr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import bbr_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam int unsigned EW = $bits(entry_t);

  state_t            state_r, state_nxt;
  logic [LBA_W-1:0]  spare_base_r, start_limit_r;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic              chk_r, chk_nxt;
  logic [LBA_W-1:0]  lba_r, lba_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LBA_W-1:0]  res_r, res_nxt;
  status_t           st_r, st_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [LBA_W-1:0]  out_start_r, out_start_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;

  logic              accept;
  logic              out_free;
  logic              hit;
  logic [CW-1:0]     fill_m1;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  entry_t            ram_wentry, ram_rentry;
  logic [EW-1:0]     ram_rdata;

  assign accept   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign fill_m1  = fill_r - CW'(1);
  assign ram_rentry = entry_t'(ram_rdata);
  assign hit = chk_r && (ram_rentry.orig_start == lba_r) && (ram_rentry.ext_length == len_r);

  assign in_chan.ready        = (state_r == S_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.new_start   = out_start_r;
  assign out_chan.entry_count = out_count_r;

  bbr_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wentry),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_chan.func == FUNC_LOOKUP) begin
            state_nxt = S_LOOK;
          end else if (in_chan.lba > start_limit_r || fill_r == DEPTH_C) begin
            state_nxt = S_DONE;
          end else if (fill_r == '0) begin
            state_nxt = S_WRITE;
          end else begin
            state_nxt = S_ADD_RD;
          end
        end
      end
      S_LOOK: begin
        if (hit || idx_r == fill_r) begin
          state_nxt = S_DONE;
        end
      end
      S_ADD_RD:  state_nxt = S_ADD_SUM;
      S_ADD_SUM: state_nxt = S_WRITE;
      S_WRITE:   state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    fill_nxt       = fill_r;
    idx_nxt        = idx_r;
    chk_nxt        = 1'b0;
    lba_nxt        = lba_r;
    len_nxt        = len_r;
    res_nxt        = res_r;
    st_nxt         = st_r;
    ram_we         = 1'b0;
    ram_waddr      = fill_r[AW-1:0];
    ram_raddr      = idx_r[AW-1:0];
    ram_wentry     = '{orig_start: lba_r, repl_start: res_r, ext_length: len_r};
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_start_nxt  = out_start_r;
    out_count_nxt  = out_count_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          lba_nxt = in_chan.lba;
          len_nxt = in_chan.run_length;
          idx_nxt = '0;
          res_nxt = '0;
          st_nxt  = ST_OK;
          if (in_chan.func == FUNC_LOOKUP) begin
            st_nxt = ST_MISS;
          end else if (in_chan.lba > start_limit_r) begin
            st_nxt = ST_LIMIT;
          end else if (fill_r == DEPTH_C) begin
            st_nxt = ST_FULL;
          end else if (fill_r == '0) begin
            res_nxt = spare_base_r;
          end
        end
      end
      S_LOOK: begin
        if (hit) begin
          st_nxt  = ST_OK;
          res_nxt = ram_rentry.repl_start;
        end else if (idx_r != fill_r) begin
          chk_nxt = 1'b1;
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_ADD_RD: begin
        ram_raddr = fill_m1[AW-1:0];
      end
      S_ADD_SUM: begin
        res_nxt = ram_rentry.repl_start + LBA_W'(ram_rentry.ext_length);
      end
      S_WRITE: begin
        ram_we   = 1'b1;
        fill_nxt = fill_r + CW'(1);
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_start_nxt  = res_r;
          out_count_nxt  = COUNT_W'(fill_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      fill_r        <= '0;
      chk_r         <= 1'b0;
      out_valid_r   <= 1'b0;
      spare_base_r  <= SPARE_BASE_RST;
      start_limit_r <= START_LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      chk_r       <= chk_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SPARE_BASE:  spare_base_r  <= cfg_wdata;
          CFG_START_LIMIT: start_limit_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    lba_r        <= lba_nxt;
    len_r        <= len_nxt;
    res_r        <= res_nxt;
    st_r         <= st_nxt;
    out_status_r <= out_status_nxt;
    out_start_r  <= out_start_nxt;
    out_count_r  <= out_count_nxt;
  end

endmodule

`default_nettype wire
